### design/ihex_pkg.sv
// Shared types, character codes and helpers of the Intel HEX dump encoder.
`default_nettype none

package ihex_pkg;

    localparam int unsigned CharW  = 7;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned AddrW  = 16;
    localparam int unsigned CountW = 13;
    localparam int unsigned IdxW   = 4;
    localparam int unsigned PhaseW = 2;

    // Output segments of one input byte, in the order they are sent.
    localparam logic [PhaseW-1:0] PH_ELA  = 2'd0;
    localparam logic [PhaseW-1:0] PH_HDR  = 2'd1;
    localparam logic [PhaseW-1:0] PH_DATA = 2'd2;
    localparam logic [PhaseW-1:0] PH_TAIL = 2'd3;

    // Index of the last character within each segment.
    localparam logic [IdxW-1:0] ELA_END  = 4'd13;
    localparam logic [IdxW-1:0] HDR_END  = 4'd11;
    localparam logic [IdxW-1:0] DATA_END = 4'd1;
    localparam logic [IdxW-1:0] TAIL_END = 4'd7;

    // Configuration register indexes.
    localparam logic REG_UPPER_ADDR = 1'b0;
    localparam logic REG_REC_COUNT  = 1'b1;

    localparam logic [CountW-1:0] REC_COUNT_RESET = 13'd2048;
    localparam logic [CountW-1:0] REC_COUNT_MAX   = 13'd4096;

    localparam logic [CharW-1:0] CH_LF    = 7'h0A;
    localparam logic [CharW-1:0] CH_COLON = 7'h3A;
    localparam logic [CharW-1:0] CH_ZERO  = 7'h30;
    localparam logic [CharW-1:0] CH_ONE   = 7'h31;
    localparam logic [CharW-1:0] CH_TWO   = 7'h32;
    localparam logic [CharW-1:0] CH_FOUR  = 7'h34;
    localparam logic [CharW-1:0] CH_E     = 7'h65;
    localparam logic [CharW-1:0] CH_N     = 7'h6E;
    localparam logic [CharW-1:0] CH_D     = 7'h64;
    localparam logic [CharW-1:0] CH_ALPHA = 7'h37;

    // Everything the character generator needs about one byte.
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic [AddrW-1:0] addr;
        logic [AddrW-1:0] upper;
        logic [ByteW-1:0] ck_prev;
        logic [ByteW-1:0] ck_final;
        logic             first;
        logic             hdr;
        logic             last;
    } ihex_item_t;

    function automatic logic [CharW-1:0] hex_char(input logic [3:0] d);
        logic [CharW-1:0] ext;
        ext = {3'b000, d};
        return (d > 4'd9) ? 7'(CH_ALPHA + ext) : 7'(CH_ZERO + ext);
    endfunction

endpackage

`default_nettype wire

### design/intel_hex_dump_encoder.sv
// Top level of the Intel HEX dump encoder: byte intake, record state and character output.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] = data_byte
//  m_*     | out | m_tvalid/m_tready  | m_tdata[6:0] = ascii_char, m_tlast = run_end
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index selects register, cfg_data value
//
// One character leaves per cycle unless m_tready stalls, so a byte yields from 2 characters
// (inside a record) to 28 characters (first byte of a dump: address record, data header and
// the byte itself); a closing byte adds 8 characters for the checksum and the end text.
// A new byte is taken in the cycle its predecessor's last character is registered.
// Reset clears address, record sum, both channels and the configuration to defaults.
// A stalled m_tready holds the output register and, behind it, the byte in work.
`default_nettype none

module intel_hex_dump_encoder
    import ihex_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] ascii_char, [7] zero
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [AddrW-1:0]  upper_reg;
    logic [CountW-1:0] count_reg;
    logic [AddrW-1:0]  addr_reg, addr_next;
    logic [ByteW-1:0]  sum_reg, sum_next;

    ihex_item_t        item_reg, item_next;
    logic              item_valid_reg, item_valid_next;
    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [IdxW-1:0]   idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [CharW-1:0]  out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic [CharW-1:0]  gen_char;
    logic              gen_seg_end;
    logic              gen_run_end;

    logic              adv;
    logic              accept;
    logic [11:0]       count_m1;
    logic [AddrW-1:0]  last_addr;
    logic [ByteW-1:0]  ela_sum;
    logic [ByteW-1:0]  base_sum;
    logic [ByteW-1:0]  final_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
            count_reg <= REC_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_UPPER_ADDR: upper_reg <= cfg_data;
                REG_REC_COUNT:  count_reg <= cfg_data[CountW-1:0];
                default:        upper_reg <= upper_reg;
            endcase
        end
    end

    ihex_char_gen u_char_gen (
        .item    (item_reg),
        .phase   (phase_reg),
        .idx     (idx_reg),
        .ascii   (gen_char),
        .seg_end (gen_seg_end),
        .run_end (gen_run_end)
    );

    assign adv      = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || (adv && gen_run_end);
    assign accept   = s_tvalid && s_tready;

    // A count of zero or beyond the maximum means a full 64 KiB dump.
    assign count_m1  = (count_reg == '0 || count_reg > REC_COUNT_MAX) ?
                       12'hFFF : 12'(count_reg - 13'd1);
    assign last_addr = {count_m1, 4'hF};

    always_comb
    begin
        ela_sum   = 8'(8'h06 + upper_reg[15:8] + upper_reg[7:0]);
        base_sum  = (addr_reg[3:0] == 4'h0) ?
                    8'(8'h10 + addr_reg[15:8] + addr_reg[7:0]) : sum_reg;
        final_sum = 8'(base_sum + s_tdata);

        item_next.data     = s_tdata;
        item_next.addr     = addr_reg;
        item_next.upper    = upper_reg;
        item_next.first    = (addr_reg == '0);
        item_next.hdr      = (addr_reg[3:0] == 4'h0);
        item_next.last     = (addr_reg >= last_addr);
        item_next.ck_prev  = item_next.first ? 8'(8'h00 - ela_sum) : 8'(8'h00 - sum_reg);
        item_next.ck_final = 8'(8'h00 - final_sum);

        addr_next = addr_reg;
        sum_next  = sum_reg;
        if (accept)
        begin
            addr_next = item_next.last ? '0 : 16'(addr_reg + 16'd1);
            sum_next  = item_next.last ? '0 : final_sum;
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
            idx_next        = '0;
            if (item_next.first)
                phase_next = PH_ELA;
            else if (item_next.hdr)
                phase_next = PH_HDR;
            else
                phase_next = PH_DATA;
        end
        else if (adv)
        begin
            if (gen_run_end)
                item_valid_next = 1'b0;
            if (gen_seg_end)
            begin
                idx_next = '0;
                case (phase_reg)
                    PH_ELA:  phase_next = PH_HDR;
                    PH_HDR:  phase_next = PH_DATA;
                    PH_DATA: phase_next = PH_TAIL;
                    default: phase_next = PH_TAIL;
                endcase
            end
            else
            begin
                idx_next = 4'(idx_reg + 4'd1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_char_next  = gen_char;
            out_last_next  = gen_run_end;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            sum_reg        <= '0;
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_DATA;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            addr_reg       <= addr_next;
            sum_reg        <= sum_next;
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### design/ihex_char_gen.sv
// Character selection for one position of one byte's output text.
`default_nettype none

module ihex_char_gen
    import ihex_pkg::*;
(
    input  wire ihex_item_t        item,
    input  wire logic [PhaseW-1:0] phase,
    input  wire logic [IdxW-1:0]   idx,
    output logic [CharW-1:0]       ascii,
    output logic                   seg_end,
    output logic                   run_end
);

    always_comb
    begin
        ascii   = CH_ZERO;
        seg_end = 1'b0;
        run_end = 1'b0;
        case (phase)
            PH_ELA:
            begin
                seg_end = (idx == ELA_END);
                case (idx)
                    4'd0:    ascii = CH_LF;
                    4'd1:    ascii = CH_COLON;
                    4'd3:    ascii = CH_TWO;
                    4'd9:    ascii = CH_FOUR;
                    4'd10:   ascii = hex_char(item.upper[15:12]);
                    4'd11:   ascii = hex_char(item.upper[11:8]);
                    4'd12:   ascii = hex_char(item.upper[7:4]);
                    4'd13:   ascii = hex_char(item.upper[3:0]);
                    default: ascii = CH_ZERO;
                endcase
            end
            PH_HDR:
            begin
                seg_end = (idx == HDR_END);
                case (idx)
                    4'd0:    ascii = hex_char(item.ck_prev[7:4]);
                    4'd1:    ascii = hex_char(item.ck_prev[3:0]);
                    4'd2:    ascii = CH_LF;
                    4'd3:    ascii = CH_COLON;
                    4'd4:    ascii = CH_ONE;
                    4'd6:    ascii = hex_char(item.addr[15:12]);
                    4'd7:    ascii = hex_char(item.addr[11:8]);
                    4'd8:    ascii = hex_char(item.addr[7:4]);
                    4'd9:    ascii = hex_char(item.addr[3:0]);
                    default: ascii = CH_ZERO;
                endcase
            end
            PH_DATA:
            begin
                seg_end = (idx == DATA_END);
                run_end = seg_end && !item.last;
                ascii   = idx[0] ? hex_char(item.data[3:0]) : hex_char(item.data[7:4]);
            end
            PH_TAIL:
            begin
                seg_end = (idx == TAIL_END);
                run_end = seg_end;
                case (idx)
                    4'd0:    ascii = hex_char(item.ck_final[7:4]);
                    4'd1:    ascii = hex_char(item.ck_final[3:0]);
                    4'd4:    ascii = CH_E;
                    4'd5:    ascii = CH_N;
                    4'd6:    ascii = CH_D;
                    default: ascii = CH_LF;
                endcase
            end
            default:
            begin
                ascii = CH_ZERO;
            end
        endcase
    end

endmodule

`default_nettype wire
